>>> rtl/assert_macros.svh
// assertion macros for the converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked at every clock outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

>>> rtl/e2d_pkg.sv
// shared constants and stage types for the extended to double converter
package e2d_pkg;
   localparam int ExtBias = 16383;
   localparam logic [14:0] ExtExpMax = 15'h7FFF;
   localparam logic [63:0] DblInf = 64'h7FF0000000000000;
   localparam logic [63:0] DblQnan = 64'h7FF8000000000000;

   // stage 1 -> stage 2: normalized mantissa and class
   typedef struct packed {
      logic        sign;
      logic        special;
      logic [62:0] special_mag;
      logic [63:0] norm;
      logic signed [16:0] e;
   } e2d_norm_type;

   // stage 2 -> stage 3: aligned mantissa with sticky
   typedef struct packed {
      logic        sign;
      logic        special;
      logic [62:0] special_mag;
      logic        ovf;
      logic [10:0] bexp;
      logic [52:0] q;
      logic        g;
      logic        st;
   } e2d_align_type;
endpackage

>>> rtl/extended_to_double_converter_top.sv
// a request passes through the n_ff, a_ff and r_ff registers on its way to rsp valid
// throughput: one item per cycle while rsp_stall is low, three register stages
// each stage advances when it is empty or the stage after it is empty or moving
// a held result stalls upstream stages without loss
// reset: synchronous active high, clears stage valid bits only
`include "assert_macros.svh"
module extended_to_double_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sign_exponent,
   input  logic [63:0] req_mantissa,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_double_bits
);
   import e2d_pkg::*;
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;
   e2d_norm_type  n_in, n_ff;
   e2d_align_type a_in, a_ff;
   logic [63:0]   r_in, r_ff;

   e2d_norm u_norm (.sign_exponent(req_sign_exponent), .mantissa(req_mantissa),
      .out_norm(n_in));
   e2d_align u_align (.in_norm(n_ff), .out_align(a_in));
   e2d_round u_round (.in_align(a_ff), .double_bits(r_in));

   // stage enables
   assign adv3 = !v3_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign rsp_valid = v3_ff;
   assign rsp_double_bits = r_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv1) n_ff <= n_in;
      if (adv2) a_ff <= a_in;
      if (adv3) r_ff <= r_in;
   end

   `ASSERT_IMPLY(a_hold, clock, reset, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_double_bits)), "held result changed")
   `ASSERT_IMPLY(a_full, clock, reset, req_stall, (v1_ff && v2_ff && v3_ff), "stall without full pipe")
   `ASSERT_ALWAYS(a_nan, clock, reset, !rsp_valid || rsp_double_bits[62:52] != 11'h7FF || rsp_double_bits[50:0] == 51'd0, "nan payload leaked")
endmodule

>>> rtl/e2d_norm.sv
// stage 1: leading one search and left normalization
module e2d_norm (
   input  logic [15:0]           sign_exponent,
   input  logic [63:0]           mantissa,
   output e2d_pkg::e2d_norm_type out_norm
);
   import e2d_pkg::*;
   logic [5:0] lz;
   logic       found;

   // count leading zeros
   always_comb begin
      lz = 6'd0;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && mantissa[i]) begin
            lz = 6'(63 - i);
            found = 1'b1;
         end
      end
   end

   // classify and normalize
   always_comb begin
      out_norm.sign = sign_exponent[15];
      out_norm.norm = mantissa << lz;
      out_norm.e = $signed({2'b00, sign_exponent[14:0]}) - 17'sd16383 - $signed({11'd0, lz});
      out_norm.special = 1'b0;
      out_norm.special_mag = 63'd0;
      if (sign_exponent[14:0] == ExtExpMax) begin
         out_norm.special = 1'b1;
         out_norm.special_mag = (mantissa == 64'd0) ? DblInf[62:0] : DblQnan[62:0];
      end else if (!found) begin
         out_norm.special = 1'b1;
      end
   end
endmodule

>>> rtl/e2d_align.sv
// stage 2: range check and right shift for subnormals
module e2d_align (
   input  e2d_pkg::e2d_norm_type  in_norm,
   output e2d_pkg::e2d_align_type out_align
);
   import e2d_pkg::*;
   logic signed [16:0] sh;
   logic [6:0]         shc;
   logic [127:0]       wide;
   logic [127:0]       shifted;

   // denormal shift is -1022 - e, clamped at 66
   always_comb begin
      sh = -17'sd1022 - in_norm.e;
      if (sh <= 17'sd0) begin
         shc = 7'd0;
      end else if (sh > 17'sd66) begin
         shc = 7'd66;
      end else begin
         shc = sh[6:0];
      end
      wide = {in_norm.norm, 64'd0};
      shifted = wide >> shc;
      out_align.sign = in_norm.sign;
      out_align.special = in_norm.special;
      out_align.special_mag = in_norm.special_mag;
      out_align.ovf = (in_norm.e > 17'sd1023);
      out_align.bexp = (sh > 17'sd0) ? 11'd0 : 11'(in_norm.e + 17'sd1022);
      out_align.q = shifted[127:75];
      out_align.g = shifted[74];
      out_align.st = |shifted[73:0];
   end
endmodule

>>> rtl/e2d_round.sv
// stage 3: round to nearest even and pack
module e2d_round (
   input  e2d_pkg::e2d_align_type in_align,
   output logic [63:0]            double_bits
);
   import e2d_pkg::*;
   logic        up;
   logic [63:0] sum;

   // biased exp field holds e+1022, the hidden bit adds one
   always_comb begin
      up = in_align.g & (in_align.st | in_align.q[0]);
      sum = {1'b0, in_align.bexp, 52'd0} + {11'd0, in_align.q} + {63'd0, up};
      if (in_align.special) begin
         double_bits = {in_align.sign, in_align.special_mag};
      end else if (in_align.ovf || sum >= DblInf) begin
         double_bits = {in_align.sign, DblInf[62:0]};
      end else begin
         double_bits = {in_align.sign, sum[62:0]};
      end
   end
endmodule
